/* design/rcms_pkg.sv */
`default_nettype none
package rcms_pkg;

  localparam int UID_W     = 56;
  localparam int UID_LEN_W = 3;
  localparam int UID_BYTES = UID_W / 8;
  localparam int TIME_W    = 32;
  localparam int DWELL_W   = 16;
  localparam int CNT32_W   = 32;

  localparam logic [DWELL_W-1:0] DWELL_RESET_MS = 16'd1000;

  localparam logic [1:0] OC_NO_CARD = 2'd0;
  localparam logic [1:0] OC_FOUND   = 2'd1;
  localparam logic [1:0] OC_CHANGED = 2'd2;
  localparam logic [1:0] OC_ERROR   = 2'd3;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_ADDED    = 2'd1;
  localparam logic [1:0] EV_REMOVED  = 2'd2;
  localparam logic [1:0] EV_UID_CHG  = 2'd3;

  typedef struct packed {
    logic [1:0]           scan_outcome;
    logic                 uid_ok;
    logic [UID_W-1:0]     uid_value;
    logic [UID_LEN_W-1:0] uid_bytes;
    logic [TIME_W-1:0]    now_ms;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         scanned_cell;
    logic [5:0]         select_cell;
    logic [1:0]         card_event;
    logic               cell_present;
    logic               cell_changed;
    logic               dwelling;
    logic               pass_done;
    logic [6:0]         cards_present;
    logic [CNT32_W-1:0] added_total;
    logic [CNT32_W-1:0] removed_total;
    logic [CNT32_W-1:0] changed_total;
  } out_item_t;

  typedef struct packed {
    logic                 present;
    logic                 changed;
    logic [UID_LEN_W-1:0] uid_len;
    logic [UID_W-1:0]     uid;
  } cache_entry_t;

  typedef struct packed {
    logic capture;
    logic update;
  } ctrl_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } state_t;

endpackage
`default_nettype wire

/* design/rcms_ctrl.sv */
`default_nettype none
module rcms_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  output rcms_pkg::ctrl_t     ctrl
);

  rcms_pkg::state_t state_r;
  rcms_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcms_pkg::ST_IDLE: begin
        if (start) state_nxt = rcms_pkg::ST_UPDATE;
      end
      rcms_pkg::ST_UPDATE: begin
        state_nxt = rcms_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rcms_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy         = (state_r != rcms_pkg::ST_IDLE);
    ctrl.capture = (state_r == rcms_pkg::ST_IDLE) && start;
    ctrl.update  = (state_r == rcms_pkg::ST_UPDATE);
  end

endmodule
`default_nettype wire

/* design/rcms_datapath.sv */
`default_nettype none
module rcms_datapath #(
  parameter int CELLS         = 64,
  parameter int UID_MAX_BYTES = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rcms_pkg::ctrl_t                 ctrl,
  input  wire rcms_pkg::in_item_t              in_item,
  input  wire logic                            cfg_we,
  input  wire logic [rcms_pkg::DWELL_W-1:0]    cfg_data,
  output logic                                 out_valid,
  output rcms_pkg::out_item_t                  out_item
);

  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);
  localparam logic [3:0]    UID_MAX   = 4'(UID_MAX_BYTES);

  // cache storage, valid bits stand in for the cleared state after reset
  rcms_pkg::cache_entry_t mem [CELLS];
  rcms_pkg::cache_entry_t rd_r;
  logic                   rd_vld_r;
  logic [CELLS-1:0]       vld_r;

  rcms_pkg::in_item_t item_r;

  logic [CW-1:0]                    cur_cell_r, cur_cell_nxt;
  logic                             last_vld_r, last_vld_nxt;
  logic [CW-1:0]                    last_cell_r, last_cell_nxt;
  logic [rcms_pkg::TIME_W-1:0]      dwell_start_r, dwell_start_nxt;
  logic [rcms_pkg::DWELL_W-1:0]     dwell_r;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [rcms_pkg::CNT32_W-1:0]     added_r, added_nxt;
  logic [rcms_pkg::CNT32_W-1:0]     removed_r, removed_nxt;
  logic [rcms_pkg::CNT32_W-1:0]     uid_chg_r, uid_chg_nxt;
  logic                             out_valid_r;
  rcms_pkg::out_item_t              out_item_r, out_item_nxt;

  rcms_pkg::cache_entry_t           old_ent;
  rcms_pkg::cache_entry_t           ent_nxt;
  logic                             wr_en;
  logic [rcms_pkg::UID_LEN_W-1:0]   len_sat;
  logic [rcms_pkg::UID_W-1:0]       uid_mask;
  logic [rcms_pkg::UID_W-1:0]       uid_m;
  logic                             is_card;
  logic                             restart;
  logic [rcms_pkg::TIME_W-1:0]      elapsed;
  logic                             dwelling;
  logic                             pass_done;
  logic [1:0]                       ev;

  always_comb begin
    old_ent = rd_vld_r ? rd_r : '0;

    if ({1'b0, item_r.uid_bytes} > UID_MAX) len_sat = UID_MAX[rcms_pkg::UID_LEN_W-1:0];
    else len_sat = item_r.uid_bytes;

    for (int b = 0; b < rcms_pkg::UID_BYTES; b++) begin
      uid_mask[b*8 +: 8] = (b < int'(len_sat)) ? 8'hFF : 8'h00;
    end
    uid_m = item_r.uid_value & uid_mask;

    is_card = (item_r.scan_outcome == rcms_pkg::OC_FOUND) ||
              (item_r.scan_outcome == rcms_pkg::OC_CHANGED);
    restart = !last_vld_r || (last_cell_r != cur_cell_r);

    last_vld_nxt    = last_vld_r;
    last_cell_nxt   = last_cell_r;
    dwell_start_nxt = dwell_start_r;
    if (is_card && restart) begin
      last_vld_nxt    = 1'b1;
      last_cell_nxt   = cur_cell_r;
      dwell_start_nxt = item_r.now_ms;
    end
    elapsed  = item_r.now_ms - dwell_start_nxt;
    dwelling = is_card && (elapsed < {16'b0, dwell_r});

    ent_nxt     = old_ent;
    wr_en       = 1'b0;
    ev          = rcms_pkg::EV_NONE;
    count_nxt   = count_r;
    added_nxt   = added_r;
    removed_nxt = removed_r;
    uid_chg_nxt = uid_chg_r;
    if (is_card && item_r.uid_ok) begin
      wr_en           = 1'b1;
      ent_nxt.present = 1'b1;
      ent_nxt.changed = (item_r.scan_outcome == rcms_pkg::OC_CHANGED);
      ent_nxt.uid_len = len_sat;
      ent_nxt.uid     = uid_m;
      if (!old_ent.present) begin
        added_nxt = added_r + 1'b1;
        count_nxt = count_r + 1'b1;
        ev        = rcms_pkg::EV_ADDED;
      end else if ((item_r.scan_outcome == rcms_pkg::OC_CHANGED) &&
                   ((old_ent.uid_len != len_sat) || (old_ent.uid != uid_m))) begin
        uid_chg_nxt = uid_chg_r + 1'b1;
        ev          = rcms_pkg::EV_UID_CHG;
      end
    end else if ((item_r.scan_outcome == rcms_pkg::OC_NO_CARD) && old_ent.present) begin
      wr_en           = 1'b1;
      ent_nxt.present = 1'b0;
      ent_nxt.changed = 1'b1;
      ent_nxt.uid_len = '0;
      ent_nxt.uid     = '0;
      removed_nxt     = removed_r + 1'b1;
      if (count_r != '0) count_nxt = count_r - 1'b1;
      ev              = rcms_pkg::EV_REMOVED;
    end

    pass_done    = 1'b0;
    cur_cell_nxt = cur_cell_r;
    if (!dwelling) begin
      if (cur_cell_r == LAST_CELL) begin
        cur_cell_nxt = '0;
        pass_done    = 1'b1;
      end else begin
        cur_cell_nxt = cur_cell_r + 1'b1;
      end
    end

    out_item_nxt.scanned_cell  = 6'(cur_cell_r);
    out_item_nxt.select_cell   = 6'(cur_cell_nxt);
    out_item_nxt.card_event    = ev;
    out_item_nxt.cell_present  = ent_nxt.present;
    out_item_nxt.cell_changed  = ent_nxt.changed;
    out_item_nxt.dwelling      = dwelling;
    out_item_nxt.pass_done     = pass_done;
    out_item_nxt.cards_present = 7'(count_nxt);
    out_item_nxt.added_total   = added_nxt;
    out_item_nxt.removed_total = removed_nxt;
    out_item_nxt.changed_total = uid_chg_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) rd_r <= mem[cur_cell_r];
    if (ctrl.update && wr_en) mem[cur_cell_r] <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      item_r   <= in_item;
      rd_vld_r <= vld_r[cur_cell_r];
    end
    if (ctrl.update) out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cell_r    <= '0;
      last_vld_r    <= 1'b0;
      last_cell_r   <= '0;
      dwell_start_r <= '0;
      dwell_r       <= rcms_pkg::DWELL_RESET_MS;
      count_r       <= '0;
      added_r       <= '0;
      removed_r     <= '0;
      uid_chg_r     <= '0;
      vld_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= ctrl.update;
      if (cfg_we) dwell_r <= cfg_data;
      if (ctrl.update) begin
        cur_cell_r    <= cur_cell_nxt;
        last_vld_r    <= last_vld_nxt;
        last_cell_r   <= last_cell_nxt;
        dwell_start_r <= dwell_start_nxt;
        count_r       <= count_nxt;
        added_r       <= added_nxt;
        removed_r     <= removed_nxt;
        uid_chg_r     <= uid_chg_nxt;
        if (wr_en) vld_r[cur_cell_r] <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CELLS))
    else $error("present count above cell count");

  a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_cell_r <= LAST_CELL)
    else $error("current cell out of range");

  a_dwell_holds_cell: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.update && dwelling |=> cur_cell_r == $past(cur_cell_r))
    else $error("cell moved while dwelling");

endmodule
`default_nettype wire

/* design/rfid_cell_matrix_scanner.sv */
`default_nettype none
// rfid cell matrix scanner
// input: an item (read outcome of the selected cell) is taken at a clock edge
//   where start is high and busy is low
// output: one result item per input, shown for one cycle with out_valid high;
//   select_cell tells the mux which cell to read next
// config: cfg_valid/cfg_ready write the dwell time in ms; cfg_ready is
//   always high; write only while no item is in flight
// flow: an item passes the registered read of the cell cache, then its
//   update and write back; busy stays high until the result strobe, and
//   the next item can be taken in the cycle that strobe is shown, so a
//   new item is not taken while the previous one is in flight
// reset: rst_n low clears the cache valid bits, the counters, the scan
//   position and sets the dwell time to 1000 ms; the cache needs no sweep
// the receiver cannot stall, so a result is lost if not taken in its cycle
module rfid_cell_matrix_scanner #(
  parameter int CELLS         = 64,
  parameter int UID_MAX_BYTES = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rcms_pkg::in_item_t            in_item,
  output logic                               out_valid,
  output rcms_pkg::out_item_t                out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rcms_pkg::DWELL_W-1:0]  cfg_data
);

  rcms_pkg::ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  rcms_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  rcms_datapath #(
    .CELLS         (CELLS),
    .UID_MAX_BYTES (UID_MAX_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("not busy after accepting an item");

  a_pass_not_dwell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.dwelling && out_item.pass_done))
    else $error("pass done while dwelling");

  a_pass_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.pass_done |-> out_item.select_cell == 6'd0)
    else $error("pass done without wrap to cell zero");

endmodule
`default_nettype wire

/* tb/sv/tb_rfid_cell_matrix_scanner.sv */
`timescale 1ns / 100ps

module tb_rfid_cell_matrix_scanner;

  localparam int NCELLS        = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEMS_PER_SET = 322;
  localparam int NUM_SETS      = 6;

  typedef struct packed {
    rcms_pkg::in_item_t  stim;
    logic                typed;
    rcms_pkg::out_item_t want;
  } scan_row_t;

  typedef struct packed {
    logic                typed;
    rcms_pkg::out_item_t want;
  } row_tag_t;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          start     = 1'b0;
  logic                          busy;
  rcms_pkg::in_item_t            in_item   = '0;
  logic                          out_valid;
  rcms_pkg::out_item_t           out_item;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rcms_pkg::DWELL_W-1:0]  cfg_data  = '0;

  rfid_cell_matrix_scanner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // scanner state as predicted
  logic [5:0]                     cur_cell;
  logic                           last_card_ok;
  logic [5:0]                     last_card;
  logic [rcms_pkg::TIME_W-1:0]    dwell_start;
  logic [rcms_pkg::DWELL_W-1:0]   dwell_ms;
  logic                           cache_present [NCELLS];
  logic                           cache_changed [NCELLS];
  logic [rcms_pkg::UID_LEN_W-1:0] cache_len     [NCELLS];
  logic [rcms_pkg::UID_W-1:0]     cache_uid     [NCELLS];
  logic [6:0]                     card_count;
  logic [31:0]                    added_cnt;
  logic [31:0]                    removed_cnt;
  logic [31:0]                    uid_chg_cnt;

  scan_row_t            scan_plan [$];
  row_tag_t             row_tags [$];
  rcms_pkg::out_item_t  pending_results [$];
  row_tag_t             tag;
  rcms_pkg::out_item_t  pred;
  rcms_pkg::out_item_t  want;
  int                   mismatch_count = 0;
  int                   cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[rfid_cell_matrix_scanner] ERROR");
      $finish;
    end
  end

  function automatic rcms_pkg::out_item_t scan_predict(input rcms_pkg::in_item_t it);
    rcms_pkg::out_item_t        r;
    logic [5:0]                 scan_idx;
    logic [rcms_pkg::UID_W-1:0] mask;
    logic [rcms_pkg::UID_W-1:0] uid;
    r = '0;
    scan_idx = cur_cell;
    mask = '0;
    for (int b = 0; b < rcms_pkg::UID_BYTES; b++) begin
      if (b < it.uid_bytes) mask[b*8 +: 8] = 8'hFF;
    end
    uid = it.uid_value & mask;
    r.card_event = rcms_pkg::EV_NONE;
    if (it.scan_outcome == rcms_pkg::OC_FOUND || it.scan_outcome == rcms_pkg::OC_CHANGED) begin
      if (it.uid_ok) begin
        if (!cache_present[scan_idx]) begin
          added_cnt = added_cnt + 1;
          card_count = card_count + 1;
          r.card_event = rcms_pkg::EV_ADDED;
        end else if (it.scan_outcome == rcms_pkg::OC_CHANGED &&
                     (cache_len[scan_idx] != it.uid_bytes ||
                      cache_uid[scan_idx] != uid)) begin
          uid_chg_cnt = uid_chg_cnt + 1;
          r.card_event = rcms_pkg::EV_UID_CHG;
        end
        cache_present[scan_idx] = 1'b1;
        cache_changed[scan_idx] = (it.scan_outcome == rcms_pkg::OC_CHANGED);
        cache_len[scan_idx] = it.uid_bytes;
        cache_uid[scan_idx] = uid;
      end
      // timer restarts only on a card cell other than the last one
      if (!last_card_ok || last_card != scan_idx) begin
        dwell_start = it.now_ms;
        last_card = scan_idx;
        last_card_ok = 1'b1;
      end
      r.dwelling = (it.now_ms - dwell_start) < {16'd0, dwell_ms};
    end else if (it.scan_outcome == rcms_pkg::OC_NO_CARD && cache_present[scan_idx]) begin
      cache_present[scan_idx] = 1'b0;
      cache_changed[scan_idx] = 1'b1;
      cache_len[scan_idx] = '0;
      cache_uid[scan_idx] = '0;
      removed_cnt = removed_cnt + 1;
      if (card_count != 0) card_count = card_count - 1;
      r.card_event = rcms_pkg::EV_REMOVED;
    end
    if (!r.dwelling) begin
      if (scan_idx == 6'(NCELLS - 1)) begin
        cur_cell = '0;
        r.pass_done = 1'b1;
      end else begin
        cur_cell = scan_idx + 6'd1;
      end
    end
    r.scanned_cell = scan_idx;
    r.select_cell = cur_cell;
    r.cell_present = cache_present[scan_idx];
    r.cell_changed = cache_changed[scan_idx];
    r.cards_present = card_count;
    r.added_total = added_cnt;
    r.removed_total = removed_cnt;
    r.changed_total = uid_chg_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) dwell_ms = cfg_data;
      if (start && !busy) begin
        tag = row_tags.pop_front();
        pred = scan_predict(in_item);
        pending_results.push_back(tag.typed ? tag.want : pred);
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_item);
        end else begin
          want = pending_results.pop_front();
          if (out_item.scanned_cell  !== want.scanned_cell  ||
              out_item.select_cell   !== want.select_cell   ||
              out_item.card_event    !== want.card_event    ||
              out_item.cell_present  !== want.cell_present  ||
              out_item.cell_changed  !== want.cell_changed  ||
              out_item.dwelling      !== want.dwelling      ||
              out_item.pass_done     !== want.pass_done     ||
              out_item.cards_present !== want.cards_present ||
              out_item.added_total   !== want.added_total   ||
              out_item.removed_total !== want.removed_total ||
              out_item.changed_total !== want.changed_total) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch: expected %p", want);
              $display("                 actual   %p", out_item);
            end
          end
        end
      end
    end
  end

  function automatic void add_row(input logic [1:0] oc, input logic ok,
                                  input logic [rcms_pkg::UID_W-1:0] uid,
                                  input logic [2:0] nbytes,
                                  input logic [31:0] now, input logic typed,
                                  input rcms_pkg::out_item_t res);
    scan_row_t row;
    row.stim.scan_outcome = oc;
    row.stim.uid_ok = ok;
    row.stim.uid_value = uid;
    row.stim.uid_bytes = nbytes;
    row.stim.now_ms = now;
    row.typed = typed;
    row.want = res;
    scan_plan.push_back(row);
  endfunction

  task automatic send_item(input rcms_pkg::in_item_t it, input logic typed,
                           input rcms_pkg::out_item_t res, input logic allow_gap);
    row_tag_t t;
    if (allow_gap && $urandom_range(0, 99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    t.typed = typed;
    t.want = res;
    row_tags.push_back(t);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_dwell(input logic [rcms_pkg::DWELL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rcms_pkg::in_item_t         rnd;
    logic [63:0]                wide;
    logic [rcms_pkg::UID_W-1:0] uid_pool [4];
    logic [31:0]                scan_now;
    logic [15:0]                set_dwell;
    int                         d;
    int                         r;

    cur_cell = '0;
    last_card_ok = 1'b0;
    last_card = '0;
    dwell_start = '0;
    dwell_ms = rcms_pkg::DWELL_RESET_MS;
    card_count = '0;
    added_cnt = '0;
    removed_cnt = '0;
    uid_chg_cnt = '0;
    for (int c = 0; c < NCELLS; c++) begin
      cache_present[c] = 1'b0;
      cache_changed[c] = 1'b0;
      cache_len[c] = '0;
      cache_uid[c] = '0;
    end
    for (int p = 0; p < 4; p++) begin
      wide = {$urandom(), $urandom()};
      uid_pool[p] = wide[rcms_pkg::UID_W-1:0];
    end

    // directed part, dwell time at its reset value
    add_row(rcms_pkg::OC_ERROR, 1'b1, 56'h12_3456_789A_BCDE, 3'd7, 32'd0, 1'b1,
            {6'd0, 6'd1, rcms_pkg::EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,
             32'd0, 32'd0, 32'd0});
    add_row(rcms_pkg::OC_NO_CARD, 1'b0, 56'h0, 3'd0, 32'd10, 1'b1,
            {6'd1, 6'd2, rcms_pkg::EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,
             32'd0, 32'd0, 32'd0});
    add_row(rcms_pkg::OC_FOUND, 1'b1, {rcms_pkg::UID_W{1'b1}}, 3'd7, 32'd0, 1'b1,
            {6'd2, 6'd2, rcms_pkg::EV_ADDED, 1'b1, 1'b0, 1'b1, 1'b0, 7'd1,
             32'd1, 32'd0, 32'd0});
    add_row(rcms_pkg::OC_FOUND, 1'b1, 56'h0, 3'd7, 32'd999, 1'b1,
            {6'd2, 6'd2, rcms_pkg::EV_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 7'd1,
             32'd1, 32'd0, 32'd0});
    add_row(rcms_pkg::OC_CHANGED, 1'b1, 56'hFF_FFFF_FFFF_FF01, 3'd1, 32'd1000, 1'b1,
            {6'd2, 6'd3, rcms_pkg::EV_UID_CHG, 1'b1, 1'b1, 1'b0, 1'b0, 7'd1,
             32'd1, 32'd0, 32'd1});
    add_row(rcms_pkg::OC_FOUND, 1'b0, 56'hA5_A5A5_A5A5_A5A5, 3'd5, 32'hFFFF_FFFF, 1'b1,
            {6'd3, 6'd3, rcms_pkg::EV_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 7'd1,
             32'd1, 32'd0, 32'd1});
    // elapsed time across the wrap of now_ms
    add_row(rcms_pkg::OC_CHANGED, 1'b0, 56'h5A_5A5A_5A5A_5A5A, 3'd2, 32'd998, 1'b1,
            {6'd3, 6'd3, rcms_pkg::EV_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 7'd1,
             32'd1, 32'd0, 32'd1});
    add_row(rcms_pkg::OC_ERROR, 1'b1, 56'h0, 3'd7, 32'd998, 1'b1,
            {6'd3, 6'd4, rcms_pkg::EV_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 7'd1,
             32'd1, 32'd0, 32'd1});
    add_row(rcms_pkg::OC_CHANGED, 1'b1, 56'hAB_CDEF_0123_4567, 3'd4, 32'd5000, 1'b0, '0);
    add_row(rcms_pkg::OC_CHANGED, 1'b1, 56'h00_0000_0123_4567, 3'd4, 32'd5500, 1'b0, '0);
    add_row(rcms_pkg::OC_CHANGED, 1'b1, 56'h00_0000_0123_4568, 3'd4, 32'd6000, 1'b0, '0);
    add_row(rcms_pkg::OC_NO_CARD, 1'b1, 56'h0, 3'd0, 32'd6500, 1'b0, '0);
    add_row(rcms_pkg::OC_FOUND, 1'b1, {rcms_pkg::UID_W{1'b1}}, 3'd0, 32'd7000, 1'b0, '0);
    add_row(rcms_pkg::OC_CHANGED, 1'b1, 56'h55_5555_5555_5555, 3'd0, 32'd7100, 1'b0, '0);
    add_row(rcms_pkg::OC_NO_CARD, 1'b0, 56'h0, 3'd0, 32'd7200, 1'b0, '0);
    add_row(rcms_pkg::OC_FOUND, 1'b1, 56'h0, 3'd3, 32'd8000, 1'b0, '0);
    add_row(rcms_pkg::OC_ERROR, 1'b0, 56'h0, 3'd3, 32'd8001, 1'b0, '0);
    add_row(rcms_pkg::OC_FOUND, 1'b1, 56'h00_0000_0000_BEEF, 3'd2, 32'd9000, 1'b0, '0);
    add_row(rcms_pkg::OC_FOUND, 1'b1, 56'h00_0000_0000_BEEF, 3'd2, 32'd9999, 1'b0, '0);
    add_row(rcms_pkg::OC_FOUND, 1'b1, 56'h00_1122_3344_5566, 3'd6, 32'd10000, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (scan_plan[i]) send_item(scan_plan[i].stim, scan_plan[i].typed,
                                     scan_plan[i].want, 1'b1);
    start <= 1'b0;
    drain_results();

    scan_now = 32'd20000;
    for (int s = 0; s < NUM_SETS; s++) begin
      case (s)
        0: set_dwell = 16'd0;
        1: set_dwell = 16'hFFFF;
        2: set_dwell = 16'd1;
        3: set_dwell = 16'($urandom_range(0, 65535));
        4: set_dwell = rcms_pkg::DWELL_RESET_MS;
        default: set_dwell = 16'($urandom_range(2, 60));
      endcase
      write_dwell(set_dwell);
      d = int'(set_dwell);
      if (s == 2) scan_now = 32'hFFFF_F000;
      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) rnd.scan_outcome = rcms_pkg::OC_FOUND;
        else if (r < 55) rnd.scan_outcome = rcms_pkg::OC_CHANGED;
        else if (r < 85) rnd.scan_outcome = rcms_pkg::OC_NO_CARD;
        else rnd.scan_outcome = rcms_pkg::OC_ERROR;
        rnd.uid_ok = ($urandom_range(0, 99) < 85);
        wide = {$urandom(), $urandom()};
        if ($urandom_range(0, 99) < 60) begin
          // pool uid, at times with random noise in bytes 4 to 6
          rnd.uid_value = uid_pool[$urandom_range(0, 3)];
          if ($urandom_range(0, 1) == 1) begin
            rnd.uid_value[rcms_pkg::UID_W-1:32] = wide[rcms_pkg::UID_W-1:32];
          end
        end else begin
          rnd.uid_value = wide[rcms_pkg::UID_W-1:0];
        end
        if ($urandom_range(0, 1) == 1) rnd.uid_bytes = ($urandom_range(0, 1) == 1) ? 3'd7 : 3'd4;
        else rnd.uid_bytes = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 3) scan_now = $urandom();
        else if ($urandom_range(0, 3) == 0) scan_now = scan_now + $urandom_range(0, 2 * d + 2);
        else scan_now = scan_now + $urandom_range(0, d / 4 + 1);
        rnd.now_ms = scan_now;
        // fourth set runs with no idling at all
        send_item(rnd, 1'b0, '0, s != 3);
      end
      start <= 1'b0;
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[rfid_cell_matrix_scanner] OK");
    end else begin
      $display("[rfid_cell_matrix_scanner] ERROR");
    end
    $finish;
  end

endmodule
